FILE: design/boxds_pkg.sv
// ----------------------------------------------------------------------------
// boxds_pkg
// Shared types and constants of the box area downscaler.
// ----------------------------------------------------------------------------
package boxds_pkg;

  localparam int unsigned SAMPLE_W       = 8;
  localparam int unsigned SUM_W          = 34;
  localparam int unsigned SRC_CFG_W      = 14;
  localparam int unsigned DST_CFG_W      = 12;
  localparam int unsigned CFG_DATA_W     = 14;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned COORD_W        = 11;
  localparam int unsigned DEST_ROW_LIMIT = 2048;
  localparam int unsigned ROW_CNT_W      = 12;
  localparam int unsigned NUM_CH_MAX     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_c0;
    logic [SAMPLE_W-1:0] sample_c1;
    logic [SAMPLE_W-1:0] sample_c2;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_c0;
    logic [SAMPLE_W-1:0] avg_c1;
    logic [SAMPLE_W-1:0] avg_c2;
    logic [COORD_W-1:0]  dest_col;
    logic [COORD_W-1:0]  dest_row;
    logic                frame_end;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW,
    S_AVG_GO,
    S_AVG_WAIT,
    S_OUT,
    S_BND_GO,
    S_BND_WAIT,
    S_INITC_GO,
    S_INITC_WAIT,
    S_INITR_GO,
    S_INITR_WAIT
  } state_e;

endpackage

FILE: design/boxds_sum_mem.sv
// ----------------------------------------------------------------------------
// boxds_sum_mem
// Per-column accumulator store, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module boxds_sum_mem #(
  parameter int unsigned WIDTH = 102,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: design/boxds_div.sv
// ----------------------------------------------------------------------------
// boxds_div
// Restoring divider, one quotient bit per cycle, shared by averages and edges.
// ----------------------------------------------------------------------------
module boxds_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic          fits;

  // one shift and subtract step
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(NW);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
      quo_d = {quo_q[NW-2:0], fits};
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/box_area_downscaler_unit.sv
// ----------------------------------------------------------------------------
// box_area_downscaler_unit
// Area-average box downscaler with a per-column accumulator memory.
// ----------------------------------------------------------------------------
// A pixel that closes no box goes through a memory read, then a modify/write.
// A pixel that closes a box then computes one average per channel in the
// shared bit-serial divider and loads the output register.
// A new box edge takes another division in the same divider.
// A configuration write restarts the frame and divides for the first column and row edges.
// Reset clears the position state; the accumulator memory is not cleared.
module box_area_downscaler_unit #(
  parameter int unsigned MAX_DEST_WIDTH = 2048,
  parameter int unsigned MAX_SOURCE_DIM = 8192,
  parameter int unsigned CHANNELS       = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  boxds_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output boxds_pkg::out_t                      out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [boxds_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SUM_W = boxds_pkg::SUM_W;
  localparam int unsigned SRC_W = $clog2(MAX_SOURCE_DIM + 1);
  localparam int unsigned AW    = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
  localparam int unsigned TCW   = AW + 1;
  localparam int unsigned RW    = boxds_pkg::ROW_CNT_W;
  localparam int unsigned MA    = (TCW > RW) ? TCW : RW;
  localparam int unsigned NUMW  = MA + SRC_W;
  localparam int unsigned NW    = (NUMW > SUM_W) ? NUMW : SUM_W;
  localparam int unsigned DVW   = 2 * SRC_W;
  localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MEM_W = CHANNELS * SUM_W;
  localparam int unsigned SMP_W = boxds_pkg::SAMPLE_W;

  boxds_pkg::state_e state_q, state_d;

  // configuration registers
  logic [boxds_pkg::SRC_CFG_W-1:0] src_w_q, src_h_q;
  logic [boxds_pkg::DST_CFG_W-1:0] dst_w_q, dst_h_q;

  // position state
  logic [SRC_W-1:0] col_q, row_q, cs_q, ce_q, rs_q, re_q, base_ce_q, base_re_q;
  logic [TCW-1:0]   tc_q;
  logic [RW-1:0]    tr_q;

  // per-item work registers
  logic [SMP_W-1:0] smp_q [CHANNELS];
  logic [SUM_W-1:0] sum_q [CHANNELS];
  logic [SMP_W-1:0] avg_q [boxds_pkg::NUM_CH_MAX];
  logic [CHW-1:0]   ch_q;
  logic [DVW-1:0]   area_q;
  logic [NUMW-1:0]  num_q;
  logic             bnd_row_q, bnd_pend_q;
  logic [boxds_pkg::COORD_W-1:0] oc_q, or_q;
  logic             ofe_q;
  logic             out_valid_q;
  boxds_pkg::out_t  out_q;

  // effective sizes after clamping
  logic [SRC_W-1:0] sw, sh, dw, dh;
  always_comb begin
    int unsigned s_w, s_h, hw, hh, d_w, d_h;
    s_w = (src_w_q == '0) ? 1 : int'(src_w_q);
    s_w = (s_w > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : s_w;
    s_h = (src_h_q == '0) ? 1 : int'(src_h_q);
    s_h = (s_h > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : s_h;
    hw  = (s_w < MAX_DEST_WIDTH) ? s_w : MAX_DEST_WIDTH;
    hh  = (s_h < boxds_pkg::DEST_ROW_LIMIT) ? s_h : boxds_pkg::DEST_ROW_LIMIT;
    d_w = (dst_w_q == '0) ? 1 : int'(dst_w_q);
    d_w = (d_w > hw) ? hw : d_w;
    d_h = (dst_h_q == '0) ? 1 : int'(dst_h_q);
    d_h = (d_h > hh) ? hh : d_h;
    sw = SRC_W'(s_w);
    sh = SRC_W'(s_h);
    dw = SRC_W'(d_w);
    dh = SRC_W'(d_h);
  end

  // handshakes
  logic in_acc, cfg_acc, out_load;
  assign in_acc   = in_valid_i && in_ready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_load = (state_q == boxds_pkg::S_OUT) && (!out_valid_q || out_ready_i);

  // accumulator memory
  logic [MEM_W-1:0] rd_data, wr_data;
  logic             mem_we;

  boxds_sum_mem #(
    .WIDTH(MEM_W),
    .DEPTH(MAX_DEST_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_addr_i(tc_q[AW-1:0]),
    .rd_data_o(rd_data),
    .wr_en_i  (mem_we),
    .wr_addr_i(tc_q[AW-1:0]),
    .wr_data_i(wr_data)
  );

  // read-modify-write decisions
  logic [SRC_W:0]   c1, r1;
  logic             open_box, last_col, last_row, row_done, frame_done, emit;
  logic [SUM_W-1:0] new_sum [CHANNELS];
  logic [SRC_W-1:0] bw, bh;
  always_comb begin
    c1         = {1'b0, col_q} + 1'b1;
    r1         = {1'b0, row_q} + 1'b1;
    open_box   = (row_q == rs_q) && (col_q == cs_q);
    last_col   = (c1 >= {1'b0, ce_q}) || (c1 >= {1'b0, sw});
    last_row   = (r1 >= {1'b0, re_q}) || (r1 >= {1'b0, sh});
    row_done   = c1 >= {1'b0, sw};
    frame_done = row_done && (r1 >= {1'b0, sh});
    emit       = last_col && last_row;
    bw         = (ce_q > cs_q) ? SRC_W'(ce_q - cs_q) : SRC_W'(1);
    bh         = (re_q > rs_q) ? SRC_W'(re_q - rs_q) : SRC_W'(1);
    for (int i = 0; i < CHANNELS; i++) begin
      new_sum[i] = open_box ? SUM_W'(smp_q[i])
                            : rd_data[i*SUM_W +: SUM_W] + SUM_W'(smp_q[i]);
      wr_data[i*SUM_W +: SUM_W] = new_sum[i];
    end
  end

  logic need_bnd;
  assign need_bnd = !frame_done && (row_done ? last_row : last_col);

  // divider operand selection
  logic            div_start, div_done;
  logic [NW-1:0]   div_num, div_q;
  logic [DVW-1:0]  div_den;
  always_comb begin
    unique case (state_q)
      boxds_pkg::S_INITC_GO, boxds_pkg::S_INITC_WAIT: begin
        div_num = NW'(sw);
        div_den = DVW'(dw);
      end
      boxds_pkg::S_INITR_GO, boxds_pkg::S_INITR_WAIT: begin
        div_num = NW'(sh);
        div_den = DVW'(dh);
      end
      boxds_pkg::S_BND_GO, boxds_pkg::S_BND_WAIT: begin
        div_num = NW'(num_q);
        div_den = bnd_row_q ? DVW'(dh) : DVW'(dw);
      end
      default: begin
        div_num = NW'(sum_q[ch_q]);
        div_den = area_q;
      end
    endcase
  end

  boxds_div #(
    .NW(NW),
    .DW(DVW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      boxds_pkg::S_IDLE: begin
        if (cfg_acc) state_d = boxds_pkg::S_INITC_GO;
        else if (in_acc) state_d = boxds_pkg::S_RMW;
      end
      boxds_pkg::S_RMW: begin
        if (emit) state_d = boxds_pkg::S_AVG_GO;
        else if (need_bnd) state_d = boxds_pkg::S_BND_GO;
        else state_d = boxds_pkg::S_IDLE;
      end
      boxds_pkg::S_AVG_GO:   state_d = boxds_pkg::S_AVG_WAIT;
      boxds_pkg::S_AVG_WAIT: begin
        if (div_done) begin
          state_d = (ch_q == CHW'(CHANNELS - 1)) ? boxds_pkg::S_OUT : boxds_pkg::S_AVG_GO;
        end
      end
      boxds_pkg::S_OUT: begin
        if (out_load) state_d = bnd_pend_q ? boxds_pkg::S_BND_GO : boxds_pkg::S_IDLE;
      end
      boxds_pkg::S_BND_GO:     state_d = boxds_pkg::S_BND_WAIT;
      boxds_pkg::S_BND_WAIT:   if (div_done) state_d = boxds_pkg::S_IDLE;
      boxds_pkg::S_INITC_GO:   state_d = boxds_pkg::S_INITC_WAIT;
      boxds_pkg::S_INITC_WAIT: if (div_done) state_d = boxds_pkg::S_INITR_GO;
      boxds_pkg::S_INITR_GO:   state_d = boxds_pkg::S_INITR_WAIT;
      boxds_pkg::S_INITR_WAIT: if (div_done) state_d = boxds_pkg::S_IDLE;
      default:                 state_d = boxds_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = (state_q == boxds_pkg::S_IDLE) && !cfg_valid_i;
    cfg_ready_o = (state_q == boxds_pkg::S_IDLE);
    mem_we      = (state_q == boxds_pkg::S_RMW);
    div_start   = (state_q == boxds_pkg::S_AVG_GO) || (state_q == boxds_pkg::S_BND_GO) ||
                  (state_q == boxds_pkg::S_INITC_GO) || (state_q == boxds_pkg::S_INITR_GO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= boxds_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, position and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= boxds_pkg::SRC_CFG_W'(1);
      src_h_q     <= boxds_pkg::SRC_CFG_W'(1);
      dst_w_q     <= boxds_pkg::DST_CFG_W'(1);
      dst_h_q     <= boxds_pkg::DST_CFG_W'(1);
      col_q       <= '0;
      row_q       <= '0;
      tc_q        <= '0;
      tr_q        <= '0;
      cs_q        <= '0;
      rs_q        <= '0;
      ce_q        <= SRC_W'(1);
      re_q        <= SRC_W'(1);
      base_ce_q   <= SRC_W'(1);
      base_re_q   <= SRC_W'(1);
      ch_q        <= '0;
      bnd_row_q   <= 1'b0;
      bnd_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // register write restarts the frame
      if (cfg_acc) begin
        unique case (cfg_index_i)
          boxds_pkg::CFG_SRC_WIDTH:  src_w_q <= boxds_pkg::SRC_CFG_W'(cfg_data_i);
          boxds_pkg::CFG_SRC_HEIGHT: src_h_q <= boxds_pkg::SRC_CFG_W'(cfg_data_i);
          boxds_pkg::CFG_DST_WIDTH:  dst_w_q <= boxds_pkg::DST_CFG_W'(cfg_data_i);
          boxds_pkg::CFG_DST_HEIGHT: dst_h_q <= boxds_pkg::DST_CFG_W'(cfg_data_i);
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
        tc_q  <= '0;
        tr_q  <= '0;
        cs_q  <= '0;
        rs_q  <= '0;
      end
      // first edges of a frame
      if (state_q == boxds_pkg::S_INITC_WAIT && div_done) begin
        base_ce_q <= SRC_W'(div_q);
        ce_q      <= SRC_W'(div_q);
      end
      if (state_q == boxds_pkg::S_INITR_WAIT && div_done) begin
        base_re_q <= SRC_W'(div_q);
        re_q      <= SRC_W'(div_q);
      end
      // advance raster position
      if (state_q == boxds_pkg::S_RMW) begin
        ch_q       <= '0;
        bnd_row_q  <= row_done;
        bnd_pend_q <= need_bnd;
        if (frame_done) begin
          col_q <= '0;
          row_q <= '0;
          tc_q  <= '0;
          tr_q  <= '0;
          cs_q  <= '0;
          rs_q  <= '0;
          ce_q  <= base_ce_q;
          re_q  <= base_re_q;
        end else if (row_done) begin
          col_q <= '0;
          tc_q  <= '0;
          cs_q  <= '0;
          ce_q  <= base_ce_q;
          row_q <= SRC_W'(r1);
          if (last_row) begin
            tr_q <= tr_q + 1'b1;
            rs_q <= re_q;
          end
        end else begin
          col_q <= SRC_W'(c1);
          if (last_col) begin
            tc_q <= tc_q + 1'b1;
            cs_q <= ce_q;
          end
        end
      end
      if (state_q == boxds_pkg::S_AVG_WAIT && div_done) begin
        ch_q <= ch_q + 1'b1;
      end
      // next box edge
      if (state_q == boxds_pkg::S_BND_WAIT && div_done) begin
        if (bnd_row_q) re_q <= SRC_W'(div_q);
        else ce_q <= SRC_W'(div_q);
      end
      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q[0] <= in_data_i.sample_c0;
      if (CHANNELS > 1) smp_q[CHANNELS > 1 ? 1 : 0] <= in_data_i.sample_c1;
      if (CHANNELS > 2) smp_q[CHANNELS > 2 ? 2 : 0] <= in_data_i.sample_c2;
    end
    if (state_q == boxds_pkg::S_RMW) begin
      for (int i = 0; i < CHANNELS; i++) sum_q[i] <= new_sum[i];
      for (int i = 0; i < boxds_pkg::NUM_CH_MAX; i++) avg_q[i] <= '0;
      area_q <= DVW'(bw * bh);
      num_q  <= row_done ? NUMW'(MA'(tr_q + RW'(2)) * sh)
                         : NUMW'(MA'(tc_q + TCW'(2)) * sw);
      oc_q   <= boxds_pkg::COORD_W'(tc_q);
      or_q   <= boxds_pkg::COORD_W'(tr_q);
      ofe_q  <= frame_done;
    end
    if (state_q == boxds_pkg::S_AVG_WAIT && div_done) begin
      avg_q[2'(ch_q)] <= div_q[SMP_W-1:0];
    end
    if (out_load) begin
      out_q.avg_c0    <= avg_q[0];
      out_q.avg_c1    <= avg_q[1];
      out_q.avg_c2    <= avg_q[2];
      out_q.dest_col  <= oc_q;
      out_q.dest_row  <= or_q;
      out_q.frame_end <= ofe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/boxds_checker.sv
// ----------------------------------------------------------------------------
// boxds_checker
// Port-level checks of the box area downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module boxds_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input boxds_pkg::in_t                   in_data_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input boxds_pkg::out_t                  out_data_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [boxds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [boxds_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // pixel and register write never taken together
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o && cfg_valid_i && cfg_ready_o))
    else $error("pixel and register write accepted together");

  // a pixel request is followed by its read-modify-write cycle
  a_rmw_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !cfg_ready_o)
    else $error("request accepted during read-modify-write");

  // a register write is followed by edge setup
  a_cfg_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o && !cfg_ready_o)
    else $error("request accepted during edge setup");

endmodule

bind box_area_downscaler_unit boxds_checker u_boxds_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the box area downscaler against a cycle-free model of the box
// averaging, over directed and random source frames and several geometries.
// ----------------------------------------------------------------------------
import boxds_pkg::*;

class box_average_board;
  // geometry registers as written
  int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  // raster and box position
  int unsigned src_col, src_row, tgt_col, tgt_row;
  int unsigned col_lo, col_hi, row_lo, row_hi;
  longint unsigned col_sum[3][2048];
  out_t pending_avgs[$];
  int unsigned fail_cnt;

  function new();
    src_w_reg = 1;
    src_h_reg = 1;
    dst_w_reg = 1;
    dst_h_reg = 1;
    fail_cnt  = 0;
    restart();
  endfunction

  function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function int unsigned eff_sw();
    return clip(src_w_reg, 1, 8192);
  endfunction

  function int unsigned eff_sh();
    return clip(src_h_reg, 1, 8192);
  endfunction

  function int unsigned eff_dw();
    return clip(dst_w_reg, 1, (eff_sw() < 2048) ? eff_sw() : 2048);
  endfunction

  function int unsigned eff_dh();
    return clip(dst_h_reg, 1, (eff_sh() < DEST_ROW_LIMIT) ? eff_sh() : DEST_ROW_LIMIT);
  endfunction

  function int unsigned edge_at(int unsigned i, int unsigned s, int unsigned d);
    longint unsigned p;
    p = longint'(i) * longint'(s);
    return int'(p / d);
  endfunction

  function void restart();
    src_col = 0;
    src_row = 0;
    tgt_col = 0;
    tgt_row = 0;
    col_lo  = 0;
    row_lo  = 0;
    col_hi  = edge_at(1, eff_sw(), eff_dw());
    row_hi  = edge_at(1, eff_sh(), eff_dh());
  endfunction

  // any register write restarts the frame
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg = val;
      CFG_SRC_HEIGHT: src_h_reg = val;
      CFG_DST_WIDTH:  dst_w_reg = val[DST_CFG_W-1:0];
      CFG_DST_HEIGHT: dst_h_reg = val[DST_CFG_W-1:0];
      default: ;
    endcase
    restart();
  endfunction

  // accumulate one source pixel, predict an average when its box closes
  function void note_pixel(in_t px);
    int unsigned sw, sh, dw, dh, c, r, t;
    bit first_px, end_col, end_row, row_done, frame_done;
    longint unsigned bw, bh, area;
    longint unsigned smp[3];
    out_t avg;
    sw = eff_sw();
    sh = eff_sh();
    dw = eff_dw();
    dh = eff_dh();
    c = src_col;
    r = src_row;
    t = (tgt_col < 2048) ? tgt_col : 2047;
    smp[0] = px.sample_c0;
    smp[1] = px.sample_c1;
    smp[2] = px.sample_c2;
    first_px   = (r == row_lo) && (c == col_lo);
    end_col    = (c + 1 >= col_hi) || (c + 1 >= sw);
    end_row    = (r + 1 >= row_hi) || (r + 1 >= sh);
    row_done   = (c + 1 >= sw);
    frame_done = row_done && (r + 1 >= sh);
    for (int k = 0; k < 3; k++) begin
      if (first_px) col_sum[k][t] = smp[k];
      else col_sum[k][t] = (col_sum[k][t] + smp[k]) & 64'h3_FFFF_FFFF;
    end
    if (end_col && end_row) begin
      bw = (col_hi > col_lo) ? col_hi - col_lo : 1;
      bh = (row_hi > row_lo) ? row_hi - row_lo : 1;
      area = bw * bh;
      avg.avg_c0    = 8'(col_sum[0][t] / area);
      avg.avg_c1    = 8'(col_sum[1][t] / area);
      avg.avg_c2    = 8'(col_sum[2][t] / area);
      avg.dest_col  = 11'(tgt_col);
      avg.dest_row  = 11'(tgt_row);
      avg.frame_end = frame_done;
      pending_avgs.push_back(avg);
    end
    if (frame_done) begin
      restart();
    end else if (row_done) begin
      src_col = 0;
      tgt_col = 0;
      col_lo  = 0;
      col_hi  = edge_at(1, sw, dw);
      src_row = r + 1;
      if (end_row) begin
        tgt_row++;
        row_lo = row_hi;
        row_hi = edge_at(tgt_row + 1, sh, dh);
      end
    end else begin
      src_col = c + 1;
      if (end_col) begin
        tgt_col++;
        col_lo = col_hi;
        col_hi = edge_at(tgt_col + 1, sw, dw);
      end
    end
  endfunction

  function void check_avg(out_t got);
    out_t exp_avg;
    if (pending_avgs.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_avg = pending_avgs.pop_front();
    if (got !== exp_avg) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("mismatch: expected %p, got %p", exp_avg, got);
    end
  endfunction
endclass

module tb_top;
  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_t in_data;
  out_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  box_average_board board;
  bit calm;
  int unsigned pixels_sent;
  int unsigned quiet_cycles;

  box_area_downscaler_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no request accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, check each accepted average
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_avg(out_data);
    end
  end

  task automatic send_pixel(in_t px);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    in_t px;
    px.sample_c0 = $urandom_range(0, 255);
    px.sample_c1 = $urandom_range(0, 255);
    px.sample_c2 = $urandom_range(0, 255);
    send_pixel(px);
  endtask

  // let the block drain before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_avgs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // valid stays up across consecutive writes, the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh);
    drain();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    cfg_valid <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_pixels(int unsigned n);
    for (int i = 0; i < n; i++) send_random_pixel();
  endtask

  initial begin
    in_t px;
    int unsigned sw, sh;
    board = new();
    calm = 1'b0;
    pixels_sent = 0;
    quiet_cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SRC_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 1x1: every pixel is its own box and frame
    for (int i = 0; i < 16; i++) begin
      px.sample_c0 = (i & 1) ? 8'hFF : 8'h00;
      px.sample_c1 = (i & 2) ? 8'hFF : 8'hAA;
      px.sample_c2 = (i & 4) ? 8'h55 : 8'hFF;
      send_pixel(px);
    end

    // out of range registers: zero sizes, oversize source, oversize dest
    set_geometry(0, 0, 0, 0);
    run_pixels(6);
    set_geometry(16383, 3, 4095, 2);
    run_pixels(60);
    // pause mid stream until every average has come
    in_valid <= 1'b0;
    while (board.pending_avgs.size() != 0) @(posedge clk);
    run_pixels(20);
    set_geometry(8192, 8192, 1, 1);
    run_pixels(30);
    set_geometry(3, 8192, 3, 2048);
    run_pixels(40);
    set_geometry(2048, 1, 2048, 1);
    run_pixels(20);
    set_geometry(7, 5, 3, 2);
    run_pixels(140);
    set_geometry(5, 5, 9, 5);
    run_pixels(50);

    // random small geometries, mostly whole frames
    while (pixels_sent < 700) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
      set_geometry(sw, sh, $urandom_range(1, sw + 2), $urandom_range(1, sh + 2));
      run_pixels($urandom_range(1, 2) * sw * sh + (($urandom_range(0, 3) == 0) ?
                 $urandom_range(1, sw * sh) : 0));
    end

    drain();
    if (board.fail_cnt == 0 && board.pending_avgs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/boxds_pkg.sv
design/boxds_sum_mem.sv
design/boxds_div.sv
design/box_area_downscaler_unit.sv
design/boxds_checker.sv
tb/tb_top.sv
